// ===== hdl/simb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// simb_pkg: shared definitions for the segmented id map builder
// Holds the field widths, the derived memory geometry, the command codes and
// the request bundle that drives the segment bitmap.
// ----------------------------------------------------------------------------
package simb_pkg;

    // Field widths of the item ports.
    localparam int ID_BITS  = 16;
    localparam int SEG_BITS = 4;
    localparam int PID_BITS = 16;
    localparam int CMD_BITS = 2;

    // Segment geometry.
    localparam int SEG_SIZE     = 1 << SEG_BITS;
    localparam int SEG_NUM_BITS = ID_BITS - SEG_BITS;
    localparam int CURSOR_BITS  = SEG_NUM_BITS + 1;

    // The segment-used bitmap is kept as words of 2^BM_WORD_BITS bits.
    localparam int BM_WORD_BITS = 4;
    localparam int BM_WORD      = 1 << BM_WORD_BITS;
    localparam int BM_ROW_BITS  = SEG_NUM_BITS - BM_WORD_BITS;
    localparam int BM_ROWS      = 1 << BM_ROW_BITS;

    // Command codes of an input item.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD   = 2'd0,
        CMD_EMIT  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Request from the controller to the segment bitmap.
    typedef struct packed {
        logic [BM_ROW_BITS-1:0]  rd_row;
        logic                    set_en;
        logic [SEG_NUM_BITS-1:0] set_seg;
        logic                    clear;
    } bm_req_t;

endpackage
`default_nettype wire

// ===== hdl/segmented_id_map_builder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_id_map_builder: sparse id-to-partition map in fixed segments
// Adds keep the smallest partition per id. Emits walk the segment bitmap from
// a cursor and stream the sixteen slots of the next used segment, or an end
// mark when none is left. Clear empties the map and rewinds the cursor.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                        Direction
//  s_        s_valid s_ready s_cmd s_entry_id s_entry_pid  in
//  m_        m_valid m_ready m_seg_base m_slot_index       out
//            m_slot_pid m_slot_valid m_last_slot m_end_of_map
//
//  One item is worked on at a time. An add does one read-modify-write of
//  the pid, slot mask and bitmap RAMs; a clear acts on acceptance. An emit
//  scans 16-segment bitmap words (at most 256 words), fetches the slot mask
//  of the first used segment and reads and outputs its slot results in turn;
//  an emit with the cursor already at the end only outputs the end mark.
//  Reset and clear act at once through per-word valid flops; no RAM sweep.
//  The input is taken again as soon as the last result of an emit sits in
//  the output register; a stall on m_ready holds the slot walk.
// ----------------------------------------------------------------------------
module segmented_id_map_builder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [simb_pkg::CMD_BITS-1:0]   s_cmd,
    input  wire logic [simb_pkg::ID_BITS-1:0]    s_entry_id,
    input  wire logic [simb_pkg::PID_BITS-1:0]   s_entry_pid,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [simb_pkg::ID_BITS-1:0]    m_seg_base,
    output logic      [simb_pkg::SEG_BITS-1:0]   m_slot_index,
    output logic      [simb_pkg::PID_BITS-1:0]   m_slot_pid,
    output logic                                 m_slot_valid,
    output logic                                 m_last_slot,
    output logic                                 m_end_of_map
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MASK,
        ST_SLOT_RD,
        ST_SLOT_OUT,
        ST_END_OUT
    } state_t;

    localparam logic [simb_pkg::CURSOR_BITS-1:0] CURSOR_END =
        simb_pkg::CURSOR_BITS'(1) << simb_pkg::SEG_NUM_BITS;

    state_t                              state_reg;
    logic [simb_pkg::CURSOR_BITS-1:0]    cursor_reg;
    logic [simb_pkg::ID_BITS-1:0]        id_reg;
    logic [simb_pkg::PID_BITS-1:0]       pid_reg;
    logic [simb_pkg::SEG_NUM_BITS-1:0]   seg_reg;
    logic [simb_pkg::SEG_BITS-1:0]       slot_reg;
    logic [simb_pkg::SEG_SIZE-1:0]       mask_reg;

    logic                                m_valid_reg;
    logic [simb_pkg::ID_BITS-1:0]        m_seg_base_reg;
    logic [simb_pkg::SEG_BITS-1:0]       m_slot_index_reg;
    logic [simb_pkg::PID_BITS-1:0]       m_slot_pid_reg;
    logic                                m_slot_valid_reg;
    logic                                m_last_slot_reg;
    logic                                m_end_of_map_reg;

    simb_pkg::bm_req_t                   bm_req;
    logic [simb_pkg::BM_WORD-1:0]        bm_word;
    logic [simb_pkg::SEG_NUM_BITS-1:0]   mask_raddr;
    logic [simb_pkg::SEG_SIZE-1:0]       mask_q;
    logic                                mask_we;
    logic [simb_pkg::SEG_SIZE-1:0]       mask_wdata;
    logic [simb_pkg::ID_BITS-1:0]        pid_raddr;
    logic [simb_pkg::PID_BITS-1:0]       pid_q;
    logic                                pid_we;

    logic                                accept;
    logic                                out_free;
    logic                                out_load;
    logic [simb_pkg::BM_ROW_BITS-1:0]    cur_row;
    logic [simb_pkg::BM_WORD-1:0]        scan_bits;
    logic [simb_pkg::BM_WORD_BITS-1:0]   scan_first;
    logic [simb_pkg::SEG_NUM_BITS-1:0]   scan_seg;
    logic                                add_seg_used;
    logic [simb_pkg::SEG_SIZE-1:0]       add_mask;
    logic                                add_slot_used;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = out_free && ((state_reg == ST_SLOT_OUT) || (state_reg == ST_END_OUT));
    assign cur_row  = cursor_reg[simb_pkg::SEG_NUM_BITS-1:simb_pkg::BM_WORD_BITS];

    // Lowest used segment at or above the cursor within the fetched word.
    assign scan_bits = bm_word & ({simb_pkg::BM_WORD{1'b1}}
                       << cursor_reg[simb_pkg::BM_WORD_BITS-1:0]);

    always_comb begin
        scan_first = '0;
        for (int i = simb_pkg::BM_WORD - 1; i >= 0; i--) begin
            if (scan_bits[i]) begin
                scan_first = simb_pkg::BM_WORD_BITS'(i);
            end
        end
    end

    assign scan_seg = {cur_row, scan_first};

    // Add: the stored slot mask counts only if its segment is marked used.
    assign add_seg_used  = bm_word[id_reg[simb_pkg::SEG_BITS+simb_pkg::BM_WORD_BITS-1:
                                          simb_pkg::SEG_BITS]];
    assign add_mask      = add_seg_used ? mask_q : '0;
    assign add_slot_used = add_mask[id_reg[simb_pkg::SEG_BITS-1:0]];

    assign pid_we     = (state_reg == ST_ADD) && (!add_slot_used || (pid_reg < pid_q));
    assign mask_we    = (state_reg == ST_ADD);
    assign mask_wdata = add_mask | (simb_pkg::SEG_SIZE'(1) << id_reg[simb_pkg::SEG_BITS-1:0]);

    // Read addresses: the incoming id while idle, the walk position otherwise.
    always_comb begin
        bm_req         = '0;
        bm_req.set_en  = (state_reg == ST_ADD);
        bm_req.set_seg = id_reg[simb_pkg::ID_BITS-1:simb_pkg::SEG_BITS];
        bm_req.clear   = accept && (s_cmd == simb_pkg::CMD_CLEAR);
        if (state_reg == ST_IDLE) begin
            bm_req.rd_row = s_entry_id[simb_pkg::ID_BITS-1:
                                       simb_pkg::SEG_BITS+simb_pkg::BM_WORD_BITS];
            mask_raddr    = s_entry_id[simb_pkg::ID_BITS-1:simb_pkg::SEG_BITS];
            pid_raddr     = s_entry_id;
        end else begin
            bm_req.rd_row = cur_row;
            mask_raddr    = (state_reg == ST_SCAN_CHK) ? scan_seg : seg_reg;
            pid_raddr     = {seg_reg, slot_reg};
        end
    end

    simb_seg_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bm_req),
        .rd_word (bm_word)
    );

    // Slot-used mask per segment; meaningful only while the segment is used.
    simb_ram #(
        .ADDR_BITS(simb_pkg::SEG_NUM_BITS),
        .DATA_BITS(simb_pkg::SEG_SIZE)
    ) u_mask_ram (
        .aclk  (aclk),
        .we    (mask_we),
        .waddr (id_reg[simb_pkg::ID_BITS-1:simb_pkg::SEG_BITS]),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_q)
    );

    // Partition per id.
    simb_ram #(
        .ADDR_BITS(simb_pkg::ID_BITS),
        .DATA_BITS(simb_pkg::PID_BITS)
    ) u_pid_ram (
        .aclk  (aclk),
        .we    (pid_we),
        .waddr (id_reg),
        .wdata (pid_reg),
        .raddr (pid_raddr),
        .rdata (pid_q)
    );

    // Controller and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        id_reg  <= s_entry_id;
                        pid_reg <= s_entry_pid;
                        case (s_cmd)
                            simb_pkg::CMD_ADD:   state_reg <= ST_ADD;
                            simb_pkg::CMD_EMIT:  state_reg <= ST_SCAN_RD;
                            simb_pkg::CMD_CLEAR: cursor_reg <= '0;
                            default:             state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ADD: begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN_RD: begin
                    state_reg <= cursor_reg[simb_pkg::SEG_NUM_BITS] ? ST_END_OUT
                                                                     : ST_SCAN_CHK;
                end
                ST_SCAN_CHK: begin
                    if (scan_bits != '0) begin
                        seg_reg   <= scan_seg;
                        state_reg <= ST_MASK;
                    end else if (cur_row == {simb_pkg::BM_ROW_BITS{1'b1}}) begin
                        cursor_reg <= CURSOR_END;
                        state_reg  <= ST_END_OUT;
                    end else begin
                        cursor_reg <= {1'b0, cur_row + simb_pkg::BM_ROW_BITS'(1),
                                       simb_pkg::BM_WORD_BITS'(0)};
                        state_reg  <= ST_SCAN_RD;
                    end
                end
                ST_MASK: begin
                    mask_reg  <= mask_q;
                    slot_reg  <= '0;
                    state_reg <= ST_SLOT_RD;
                end
                ST_SLOT_RD: begin
                    state_reg <= ST_SLOT_OUT;
                end
                ST_SLOT_OUT: begin
                    if (out_free) begin
                        m_seg_base_reg   <= {seg_reg, simb_pkg::SEG_BITS'(0)};
                        m_slot_index_reg <= slot_reg;
                        m_slot_pid_reg   <= mask_reg[slot_reg] ? pid_q : '0;
                        m_slot_valid_reg <= mask_reg[slot_reg];
                        m_last_slot_reg  <= (slot_reg == {simb_pkg::SEG_BITS{1'b1}});
                        m_end_of_map_reg <= 1'b0;
                        if (slot_reg == {simb_pkg::SEG_BITS{1'b1}}) begin
                            cursor_reg <= {1'b0, seg_reg} + simb_pkg::CURSOR_BITS'(1);
                            state_reg  <= ST_IDLE;
                        end else begin
                            slot_reg  <= slot_reg + simb_pkg::SEG_BITS'(1);
                            state_reg <= ST_SLOT_RD;
                        end
                    end
                end
                ST_END_OUT: begin
                    if (out_free) begin
                        m_seg_base_reg   <= '0;
                        m_slot_index_reg <= '0;
                        m_slot_pid_reg   <= '0;
                        m_slot_valid_reg <= 1'b0;
                        m_last_slot_reg  <= 1'b1;
                        m_end_of_map_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_seg_base   = m_seg_base_reg;
    assign m_slot_index = m_slot_index_reg;
    assign m_slot_pid   = m_slot_pid_reg;
    assign m_slot_valid = m_slot_valid_reg;
    assign m_last_slot  = m_last_slot_reg;
    assign m_end_of_map = m_end_of_map_reg;

    // The cursor never runs past the end-of-map position.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= CURSOR_END)
        else $error("emit cursor beyond end of map");

    // A segment chosen for output always holds at least one entry.
    a_seg_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLOT_OUT) |-> (mask_reg != '0))
        else $error("emitted segment has an empty slot mask");

    // An end mark is always the last result and carries no slot.
    a_end_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_map) |-> (m_last_slot && !m_slot_valid))
        else $error("malformed end mark");

    // An add item blocks the input for its write-back cycle.
    a_add_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == simb_pkg::CMD_ADD)) |=> !s_ready)
        else $error("input taken during add write-back");

    // An empty slot never reports a partition.
    a_hole_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_slot_valid) |-> (m_slot_pid == '0))
        else $error("hole result with nonzero partition");

endmodule
`default_nettype wire

// ===== hdl/simb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// simb_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address. Contents are undefined until written.
// ----------------------------------------------------------------------------
module simb_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/simb_seg_bitmap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// simb_seg_bitmap: one used bit per segment
// The bits live in a RAM of 16-bit words. Each word has a valid flop that
// reset and the clear request drop at once; a word that is not valid reads
// as zero. A set request merges one bit into the word that was read in the
// previous cycle, so the caller must have read that word first.
// ----------------------------------------------------------------------------
module simb_seg_bitmap (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire simb_pkg::bm_req_t                 req,
    output logic      [simb_pkg::BM_WORD-1:0]      rd_word
);

    logic [simb_pkg::BM_ROWS-1:0]     row_vld_reg;
    logic                             rd_vld_reg;
    logic [simb_pkg::BM_WORD-1:0]     ram_q;
    logic [simb_pkg::BM_ROW_BITS-1:0] wr_row;
    logic [simb_pkg::BM_WORD-1:0]     wr_word;

    // Merge the new bit into the word fetched last cycle.
    assign wr_row  = req.set_seg[simb_pkg::SEG_NUM_BITS-1:simb_pkg::BM_WORD_BITS];
    assign wr_word = rd_word | (simb_pkg::BM_WORD'(1)
                     << req.set_seg[simb_pkg::BM_WORD_BITS-1:0]);

    simb_ram #(
        .ADDR_BITS(simb_pkg::BM_ROW_BITS),
        .DATA_BITS(simb_pkg::BM_WORD)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.set_en),
        .waddr (wr_row),
        .wdata (wr_word),
        .raddr (req.rd_row),
        .rdata (ram_q)
    );

    // Word valid flops, cleared as a whole.
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            row_vld_reg <= '0;
        end else if (req.set_en) begin
            row_vld_reg[wr_row] <= 1'b1;
        end
    end

    // Valid flag of the word being read, aligned with the RAM data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= row_vld_reg[req.rd_row];
        end
    end

    assign rd_word = rd_vld_reg ? ram_q : '0;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for segmented_id_map_builder
// Drives add, emit, clear and unused-command items over the input channel
// with random pacing, predicts every slot result with a shadow copy of the
// id map, and checks each result on the output channel in order. Directed
// parts cover field extremes, repeated ids, adds behind the emit cursor and
// the exhausted map. An output hold-off and a full drain put pressure on
// the handshakes. Random traffic then follows.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_IDS      = 1 << simb_pkg::ID_BITS;
    localparam int NUM_SEGS     = 1 << simb_pkg::SEG_NUM_BITS;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 600;

    // Command value that the block ignores.
    localparam logic [simb_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    // One slot result as it appears on the output channel.
    typedef struct packed {
        logic [simb_pkg::ID_BITS-1:0]  seg_base;
        logic [simb_pkg::SEG_BITS-1:0] slot_index;
        logic [simb_pkg::PID_BITS-1:0] slot_pid;
        logic                          slot_valid;
        logic                          last_slot;
        logic                          end_of_map;
    } map_slot_t;

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic [simb_pkg::CMD_BITS-1:0] s_cmd        = simb_pkg::CMD_ADD;
    logic [simb_pkg::ID_BITS-1:0]  s_entry_id   = '0;
    logic [simb_pkg::PID_BITS-1:0] s_entry_pid  = '0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic [simb_pkg::ID_BITS-1:0]  m_seg_base;
    logic [simb_pkg::SEG_BITS-1:0] m_slot_index;
    logic [simb_pkg::PID_BITS-1:0] m_slot_pid;
    logic                          m_slot_valid;
    logic                          m_last_slot;
    logic                          m_end_of_map;

    // Shadow copy of the id map.
    logic [simb_pkg::PID_BITS-1:0] map_pid [0:NUM_IDS-1];
    bit                            map_present [0:NUM_IDS-1];
    bit                            seg_used [0:NUM_SEGS-1];
    int                            next_seg = 0;

    map_slot_t pending_slots[$];
    int        error_count  = 0;
    int        stuck_cycles = 0;

    // Pacing controls shared by the sender, the receiver and the tests.
    bit tx_paced    = 1'b1;
    bit rx_paced    = 1'b1;
    bit tx_offering = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    int rx_wait     = 0;
    int rx_stall;

    segmented_id_map_builder uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_entry_id   (s_entry_id),
        .s_entry_pid  (s_entry_pid),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_seg_base   (m_seg_base),
        .m_slot_index (m_slot_index),
        .m_slot_pid   (m_slot_pid),
        .m_slot_valid (m_slot_valid),
        .m_last_slot  (m_last_slot),
        .m_end_of_map (m_end_of_map)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Empty the shadow map and rewind the cursor.
    function automatic void clear_shadow_map();
        foreach (map_present[i]) map_present[i] = 1'b0;
        foreach (seg_used[i]) seg_used[i] = 1'b0;
        next_seg = 0;
    endfunction

    // Apply one accepted item to the shadow map and queue the slots it yields.
    function automatic void predict_map_item(logic [simb_pkg::CMD_BITS-1:0] cmd,
                                             logic [simb_pkg::ID_BITS-1:0] id,
                                             logic [simb_pkg::PID_BITS-1:0] pid);
        map_slot_t slot;
        int        seg;
        int        base;
        case (cmd)
            simb_pkg::CMD_ADD: begin
                if (!map_present[id] || pid < map_pid[id])
                    map_pid[id] = pid;
                map_present[id] = 1'b1;
                seg_used[id >> simb_pkg::SEG_BITS] = 1'b1;
            end
            simb_pkg::CMD_EMIT: begin
                seg = next_seg;
                while (seg < NUM_SEGS && !seg_used[seg])
                    seg++;
                if (seg >= NUM_SEGS) begin
                    // Nothing left: a single end mark, cursor parked at the end.
                    next_seg = NUM_SEGS;
                    slot = '0;
                    slot.last_slot = 1'b1;
                    slot.end_of_map = 1'b1;
                    pending_slots.insert(pending_slots.size(), slot);
                end else begin
                    base = seg << simb_pkg::SEG_BITS;
                    for (int s = 0; s < simb_pkg::SEG_SIZE; s++) begin
                        slot = '0;
                        slot.seg_base   = base[simb_pkg::ID_BITS-1:0];
                        slot.slot_index = s[simb_pkg::SEG_BITS-1:0];
                        slot.slot_valid = map_present[base + s];
                        slot.slot_pid   = map_present[base + s] ? map_pid[base + s] : '0;
                        slot.last_slot  = (s == simb_pkg::SEG_SIZE - 1);
                        pending_slots.insert(pending_slots.size(), slot);
                    end
                    next_seg = seg + 1;
                end
            end
            simb_pkg::CMD_CLEAR: clear_shadow_map();
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        map_slot_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_slots.size() == 0) begin
                $error("unexpected result: seg_base %0h slot_index %0h",
                       m_seg_base, m_slot_index);
                error_count++;
            end else begin
                want = pending_slots.pop_front();
                check_field("seg_base",   want.seg_base,   m_seg_base);
                check_field("slot_index", want.slot_index, m_slot_index);
                check_field("slot_pid",   want.slot_pid,   m_slot_pid);
                check_field("slot_valid", want.slot_valid, m_slot_valid);
                check_field("last_slot",  want.last_slot,  m_last_slot);
                check_field("end_of_map", want.end_of_map, m_end_of_map);
            end
        end
    end

    // Receiver pacing: a random stall after each result, or a long hold-off
    // when a test asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
            hold_active <= 1'b0;
        end else if (hold_req && !hold_active) begin
            hold_active <= 1'b1;
            m_ready <= 1'b0;
            rx_wait <= HOLD_CYCLES;
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else if (rx_wait == 1) begin
            rx_wait <= 0;
            m_ready <= 1'b1;
            hold_active <= 1'b0;
        end else if (m_ready && m_valid) begin
            rx_stall = rx_paced ? $urandom_range(0, 16) : 0;
            if (rx_stall > 0) begin
                m_ready <= 1'b0;
                rx_wait <= rx_stall;
            end
        end else if (!m_ready) begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_item(logic [simb_pkg::CMD_BITS-1:0] cmd,
                             logic [simb_pkg::ID_BITS-1:0] id,
                             logic [simb_pkg::PID_BITS-1:0] pid);
        int gap;
        gap = tx_paced ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            if (tx_offering) begin
                s_valid <= 1'b0;
                tx_offering = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_entry_id  <= id;
        s_entry_pid <= pid;
        tx_offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_map_item(cmd, id, pid);
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic wait_results_drained();
        if (tx_offering) begin
            s_valid <= 1'b0;
            tx_offering = 1'b0;
        end
        do @(posedge aclk); while (pending_slots.size() != 0);
    endtask

    // Field extremes, repeated ids and the exhausted map.
    task automatic test_field_extremes();
        send_item(simb_pkg::CMD_ADD, 16'h0000, 16'hFFFF);
        send_item(simb_pkg::CMD_ADD, 16'hFFFF, 16'h0000);
        // Repeated id: a smaller partition replaces, a larger one does not.
        send_item(simb_pkg::CMD_ADD, 16'h0000, 16'h1234);
        send_item(simb_pkg::CMD_ADD, 16'h0000, 16'hFFFF);
        send_item(simb_pkg::CMD_ADD, 16'h8000, 16'h8000);
        send_item(simb_pkg::CMD_ADD, 16'h7FFF, 16'h7FFF);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        // Map exhausted twice in a row.
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
    endtask

    // Adds behind and ahead of the cursor, clear, and the ignored command.
    task automatic test_cursor_and_clear();
        send_item(simb_pkg::CMD_ADD, 16'h0003, 16'h0009);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_CLEAR, '0, '0);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_ADD, 16'h0010, 16'h0005);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        send_item(simb_pkg::CMD_ADD, 16'h0022, 16'h0007);
        send_item(simb_pkg::CMD_ADD, 16'h0011, 16'h0001);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
    endtask

    // The receiver holds off while emits keep coming, so the block stalls.
    task automatic test_output_hold_off();
        wait_results_drained();
        send_item(simb_pkg::CMD_CLEAR, '0, '0);
        for (int i = 0; i < 6; i++)
            send_item(simb_pkg::CMD_ADD, {12'(5 + i % 3), 4'($urandom_range(0, 15))},
                      16'($urandom));
        if (tx_offering) begin
            s_valid <= 1'b0;
            tx_offering = 1'b0;
        end
        hold_req = 1'b1;
        do @(posedge aclk); while (!hold_active);
        hold_req = 1'b0;
        for (int i = 0; i < 4; i++)
            send_item(simb_pkg::CMD_EMIT, '0, '0);
        send_item(simb_pkg::CMD_ADD, 16'h0123, 16'h0042);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
    endtask

    // The sender pauses until all results are in, then resumes.
    task automatic test_drain_pause();
        send_item(simb_pkg::CMD_CLEAR, '0, '0);
        send_item(simb_pkg::CMD_ADD, 16'hABCD, 16'h5555);
        send_item(simb_pkg::CMD_EMIT, '0, '0);
        wait_results_drained();
        send_item(simb_pkg::CMD_EMIT, '0, '0);
    endtask

    // Random traffic: mostly adds into a few hot segments and emits, with
    // clears, scattered adds and ignored commands mixed in.
    task automatic test_random_traffic();
        logic [simb_pkg::SEG_NUM_BITS-1:0] hot [4];
        logic [simb_pkg::ID_BITS-1:0]      id;
        logic [simb_pkg::PID_BITS-1:0]     pid;
        int                                sent;
        int                                pick;
        for (int chunk = 0; chunk < 8; chunk++) begin
            foreach (hot[k])
                hot[k] = simb_pkg::SEG_NUM_BITS'($urandom_range(0, NUM_SEGS - 1));
            if (chunk == 0) begin
                hot[0] = '0;
                hot[1] = '1;
            end
            tx_paced = ($urandom_range(0, 3) != 0);
            rx_paced = ($urandom_range(0, 3) != 0);
            send_item(simb_pkg::CMD_CLEAR, '0, '0);
            sent = 1;
            while (sent < 25) begin
                pick = $urandom_range(0, 99);
                pid = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
                if (pick < 60) begin
                    id = {hot[$urandom_range(0, 3)], 4'($urandom_range(0, 15))};
                    send_item(simb_pkg::CMD_ADD, id, pid);
                    sent++;
                end else if (pick < 68) begin
                    send_item(simb_pkg::CMD_ADD, 16'($urandom), pid);
                    sent++;
                end else if (pick < 92) begin
                    send_item(simb_pkg::CMD_EMIT, 16'($urandom), 16'($urandom));
                    sent++;
                end else if (pick < 95) begin
                    send_item(simb_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom));
                    sent++;
                end else begin
                    send_item(CMD_UNUSED, 16'($urandom), 16'($urandom));
                end
            end
        end
        tx_paced = 1'b1;
        rx_paced = 1'b1;
    endtask

    initial begin
        clear_shadow_map();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_cursor_and_clear();
        test_output_hold_off();
        test_drain_pause();
        test_random_traffic();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
